/* design/tpc_pkg.sv */
`timescale 1ns / 1ps
// Package for the TLB / page table / cache lookup block.
// Holds store sizes, action and status codes and the item and result structs.
package tpc_pkg;

    localparam int TLB_ENTRIES  = 8;
    localparam int PAGE_ENTRIES = 16;
    localparam int CACHE_LINES  = 16;

    localparam int ACTION_W = 2;
    localparam int SLOT_W   = 4;
    localparam int VA_W     = 12;
    localparam int TSET_W   = 2;
    localparam int TTAG_W   = 4;
    localparam int VPN_W    = 6;
    localparam int PPN_W    = 8;
    localparam int CIDX_W   = 4;
    localparam int LINE_W   = 32;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_XLATE   = 2'd0,
        ACT_TLB_WR  = 2'd1,
        ACT_PAGE_WR = 2'd2,
        ACT_LINE_WR = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_TLB_HIT = 2'd1,
        ST_PT_HIT  = 2'd2,
        ST_MISS    = 2'd3
    } t_status;

    typedef struct packed {
        t_action           action;
        logic [SLOT_W-1:0] slot;
        logic [VA_W-1:0]   virtual_address;
        logic [TSET_W-1:0] tlb_set;
        logic [TTAG_W-1:0] tlb_tag;
        logic [VPN_W-1:0]  page_number;
        logic [PPN_W-1:0]  phys_page;
        logic [CIDX_W-1:0] cache_set;
        logic [LINE_W-1:0] line_bytes;
    } t_item;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        t_status           status;
    } t_result;

endpackage

/* design/tpc_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the lookup block's request and result.
// Widths come from tpc_pkg.
interface tpc_in_if;
    logic                      valid;
    logic                      ready;
    logic [tpc_pkg::ACTION_W-1:0] action;
    logic [tpc_pkg::SLOT_W-1:0]   slot;
    logic [tpc_pkg::VA_W-1:0]     virtual_address;
    logic [tpc_pkg::TSET_W-1:0]   tlb_set;
    logic [tpc_pkg::TTAG_W-1:0]   tlb_tag;
    logic [tpc_pkg::VPN_W-1:0]    page_number;
    logic [tpc_pkg::PPN_W-1:0]    phys_page;
    logic [tpc_pkg::CIDX_W-1:0]   cache_set;
    logic [tpc_pkg::LINE_W-1:0]   line_bytes;

    modport source (output valid, action, slot, virtual_address, tlb_set, tlb_tag,
                    page_number, phys_page, cache_set, line_bytes, input ready);
    modport sink   (input valid, action, slot, virtual_address, tlb_set, tlb_tag,
                    page_number, phys_page, cache_set, line_bytes, output ready);
endinterface

interface tpc_out_if;
    logic                         valid;
    logic                         ready;
    logic [tpc_pkg::BYTE_W-1:0]   data_byte;
    logic [tpc_pkg::STATUS_W-1:0] status;

    modport source (output valid, data_byte, status, input ready);
    modport sink   (input valid, data_byte, status, output ready);
endinterface

/* design/tpc_store.sv */
`timescale 1ns / 1ps
// TLB, page table and cache line stores with their associative lookup.
// Depends on tpc_pkg; writes land on the clock edge, lookup is combinational.
module tpc_store (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  tpc_pkg::t_item   i_item,
    output tpc_pkg::t_result o_res
);
    import tpc_pkg::*;

    logic              r_tlb_vld [TLB_ENTRIES];
    logic [TSET_W-1:0] r_tlb_set [TLB_ENTRIES];
    logic [TTAG_W-1:0] r_tlb_tag [TLB_ENTRIES];
    logic [PPN_W-1:0]  r_tlb_ppn [TLB_ENTRIES];

    logic              r_pg_vld [PAGE_ENTRIES];
    logic [VPN_W-1:0]  r_pg_vpn [PAGE_ENTRIES];
    logic [PPN_W-1:0]  r_pg_ppn [PAGE_ENTRIES];

    logic              r_ln_vld   [CACHE_LINES];
    logic [CIDX_W-1:0] r_ln_idx   [CACHE_LINES];
    logic [PPN_W-1:0]  r_ln_tag   [CACHE_LINES];
    logic [LINE_W-1:0] r_ln_bytes [CACHE_LINES];

    logic              w_tlb_wr;
    logic              w_pg_wr;
    logic              w_ln_wr;
    logic [VPN_W-1:0]  w_vpn;
    logic [CIDX_W-1:0] w_cidx;
    logic [1:0]        w_sel;
    logic              w_tlb_hit;
    logic [PPN_W-1:0]  w_tlb_ppn;
    logic              w_pg_hit;
    logic [PPN_W-1:0]  w_pg_ppn;
    logic [PPN_W-1:0]  w_ppn;
    logic              w_ln_hit;
    logic [LINE_W-1:0] w_ln_bytes;
    logic [BYTE_W-1:0] w_byte;

    assign w_tlb_wr = i_wr_en && (i_item.action == ACT_TLB_WR);
    assign w_pg_wr  = i_wr_en && (i_item.action == ACT_PAGE_WR);
    assign w_ln_wr  = i_wr_en && (i_item.action == ACT_LINE_WR);

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < TLB_ENTRIES; k++) begin
            if (!i_rst_n) begin
                r_tlb_vld[k] <= 1'b0;
            end else if (w_tlb_wr && (int'(i_item.slot[2:0]) == k)) begin
                r_tlb_vld[k] <= 1'b1;
            end
        end
        for (int k = 0; k < PAGE_ENTRIES; k++) begin
            if (!i_rst_n) begin
                r_pg_vld[k] <= 1'b0;
            end else if (w_pg_wr && (int'(i_item.slot) == k)) begin
                r_pg_vld[k] <= 1'b1;
            end
        end
        for (int k = 0; k < CACHE_LINES; k++) begin
            if (!i_rst_n) begin
                r_ln_vld[k] <= 1'b0;
            end else if (w_ln_wr && (int'(i_item.slot) == k)) begin
                r_ln_vld[k] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < TLB_ENTRIES; k++) begin
            if (w_tlb_wr && (int'(i_item.slot[2:0]) == k)) begin
                r_tlb_set[k] <= i_item.tlb_set;
                r_tlb_tag[k] <= i_item.tlb_tag;
                r_tlb_ppn[k] <= i_item.phys_page;
            end
        end
        for (int k = 0; k < PAGE_ENTRIES; k++) begin
            if (w_pg_wr && (int'(i_item.slot) == k)) begin
                r_pg_vpn[k] <= i_item.page_number;
                r_pg_ppn[k] <= i_item.phys_page;
            end
        end
        for (int k = 0; k < CACHE_LINES; k++) begin
            if (w_ln_wr && (int'(i_item.slot) == k)) begin
                r_ln_tag[k]   <= i_item.phys_page;
                r_ln_idx[k]   <= i_item.cache_set;
                r_ln_bytes[k] <= i_item.line_bytes;
            end
        end
    end

    assign w_vpn  = i_item.virtual_address[11:6];
    assign w_cidx = i_item.virtual_address[5:2];
    assign w_sel  = i_item.virtual_address[1:0];

    // scan high to low so the lowest matching entry wins
    always_comb begin
        w_tlb_hit = 1'b0;
        w_tlb_ppn = '0;
        for (int k = TLB_ENTRIES - 1; k >= 0; k--) begin
            if (r_tlb_vld[k] && (r_tlb_tag[k] == i_item.virtual_address[11:8])
                    && (r_tlb_set[k] == i_item.virtual_address[7:6])) begin
                w_tlb_hit = 1'b1;
                w_tlb_ppn = r_tlb_ppn[k];
            end
        end
    end

    always_comb begin
        w_pg_hit = 1'b0;
        w_pg_ppn = '0;
        for (int k = PAGE_ENTRIES - 1; k >= 0; k--) begin
            if (r_pg_vld[k] && (r_pg_vpn[k] == w_vpn)) begin
                w_pg_hit = 1'b1;
                w_pg_ppn = r_pg_ppn[k];
            end
        end
    end

    assign w_ppn = w_tlb_hit ? w_tlb_ppn : w_pg_ppn;

    always_comb begin
        w_ln_hit   = 1'b0;
        w_ln_bytes = '0;
        for (int k = CACHE_LINES - 1; k >= 0; k--) begin
            if (r_ln_vld[k] && (r_ln_tag[k] == w_ppn) && (r_ln_idx[k] == w_cidx)) begin
                w_ln_hit   = 1'b1;
                w_ln_bytes = r_ln_bytes[k];
            end
        end
    end

    always_comb begin
        case (w_sel)
            2'd0:    w_byte = w_ln_bytes[7:0];
            2'd1:    w_byte = w_ln_bytes[15:8];
            2'd2:    w_byte = w_ln_bytes[23:16];
            2'd3:    w_byte = w_ln_bytes[31:24];
            default: w_byte = '0;
        endcase
    end

    always_comb begin
        o_res.data_byte = '0;
        o_res.status    = ST_DONE;
        if (i_item.action == ACT_XLATE) begin
            if ((w_tlb_hit || w_pg_hit) && w_ln_hit) begin
                o_res.data_byte = w_byte;
                o_res.status    = w_tlb_hit ? ST_TLB_HIT : ST_PT_HIT;
            end else begin
                o_res.status    = ST_MISS;
            end
        end
    end

endmodule

/* design/tlb_page_table_cache_lookup_top.sv */
`timescale 1ns / 1ps
// Top level of the TLB / page table / cache lookup block.
// Depends on tpc_pkg, tpc_in_if, tpc_out_if and tpc_store.
//
// Usage:
//   i_in is a valid/ready request channel. Each transfer is either a write of
//   a TLB entry, a page entry or a cache line at a slot, or a translate of a
//   12-bit virtual address. o_out returns exactly one result per request:
//   data_byte and status (write done, hit via TLB, hit via page table, or
//   cannot be determined, where data_byte is zero).
//   The transfer loads the input register; the result register is loaded
//   from it once the output is free to advance, and lookup and store update
//   sit between the two registers.
//   Throughput: one request per cycle unless o_out.ready stalls; each request
//   uses the single lookup stage; a write is visible to the very next request.
//   Reset (i_rst_n low, synchronous) empties both pipeline registers and
//   clears every valid bit of the TLB, page table and cache lines.
//   When the receiver holds o_out.ready low, the result register holds and
//   the input register still takes one more request; after that i_in.ready
//   drops until the result is taken.
module tlb_page_table_cache_lookup_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tpc_in_if.sink     i_in,
    tpc_out_if.source  o_out
);
    import tpc_pkg::*;

    logic    r_s1_vld;
    t_item   r_s1_item;
    logic    r_out_vld;
    t_result r_out_res;

    t_item   w_in_item;
    t_result w_res;
    logic    w_adv;
    logic    w_s1_go;
    logic    w_in_go;

    assign w_adv   = !r_out_vld || o_out.ready;
    assign w_s1_go = r_s1_vld && w_adv;
    assign w_in_go = i_in.valid && i_in.ready;

    assign i_in.ready = !r_s1_vld || w_adv;

    always_comb begin
        w_in_item.action          = t_action'(i_in.action);
        w_in_item.slot            = i_in.slot;
        w_in_item.virtual_address = i_in.virtual_address;
        w_in_item.tlb_set         = i_in.tlb_set;
        w_in_item.tlb_tag         = i_in.tlb_tag;
        w_in_item.page_number     = i_in.page_number;
        w_in_item.phys_page       = i_in.phys_page;
        w_in_item.cache_set       = i_in.cache_set;
        w_in_item.line_bytes      = i_in.line_bytes;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_s1_vld <= i_in.valid;
            end
            if (w_adv) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_go) begin
            r_s1_item <= w_in_item;
        end
        if (w_s1_go) begin
            r_out_res <= w_res;
        end
    end

    tpc_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (w_s1_go),
        .i_item  (r_s1_item),
        .o_res   (w_res)
    );

    assign o_out.valid     = r_out_vld;
    assign o_out.data_byte = r_out_res.data_byte;
    assign o_out.status    = r_out_res.status;

    a_no_data_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && ((r_out_res.status == ST_DONE) || (r_out_res.status == ST_MISS))
        |-> (r_out_res.data_byte == '0))
        else $error("nonzero data on write or miss result");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !w_adv |=> r_s1_vld && $stable(r_s1_item))
        else $error("stalled request lost from input register");

    a_out_from_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_s1_vld))
        else $error("result appeared without a request");

    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_vld |-> i_in.ready)
        else $error("empty pipeline refused a request");

endmodule
